// ===== hdl/agc_pkg.sv =====
// ----------------------------------------------------------------------------
// agc_pkg
// Shared types and constants of the automatic gain control block.
// ----------------------------------------------------------------------------
package agc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 32;
  localparam int LEVEL_W   = 15;
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // one quotient bit per step: (target << 16) / (|x| + 1) has 31 bits
  localparam int DIV_STEPS = LEVEL_W + 16;
  localparam int Q_W       = DIV_STEPS;
  localparam int CNT_W     = 5;
  localparam int REM_W     = SAMPLE_W + 1;

  localparam int MUL_A_W = GAIN_W;
  localparam int MUL_B_W = RATE_W + 1;
  localparam int P_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = P_W + 1;

  localparam logic [GAIN_W-1:0]  GAIN_ONE = 32'd65536;
  localparam logic [MUL_B_W-1:0] W_ONE    = 17'd65536;
  localparam logic [SUM_W-1:0]   ROUND    = 50'd32768;

  localparam logic [LEVEL_W-1:0] TARGET_RST = 15'd16384;
  localparam logic [RATE_W-1:0]  ATTACK_RST = 16'd328;
  localparam logic [RATE_W-1:0]  DECAY_RST  = 16'd65470;
  localparam logic [LEVEL_W-1:0] THRESH_RST = 15'd164;
  localparam logic [RATE_W-1:0]  SCALE_RST  = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET  = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_DECAY   = 3'd2,
    REG_THRESH  = 3'd3,
    REG_SCALE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] target;
    logic [RATE_W-1:0]  attack;
    logic [RATE_W-1:0]  decay;
    logic [LEVEL_W-1:0] thresh;
    logic [RATE_W-1:0]  scale;
  } cfg_t;

  // datapath commands, at most one set per cycle
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_g;
    logic mul_d;
    logic upd;
    logic mul_y;
    logic sat;
    logic mul_s;
    logic fin;
  } cmd_t;

endpackage

// ===== hdl/agc_regs.sv =====
// ----------------------------------------------------------------------------
// agc_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module agc_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [agc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [agc_pkg::CFG_DAT_W-1:0]   cfg_data,
  output agc_pkg::cfg_t                   cfg
);
  import agc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET: cfg_nxt.target = cfg_data[LEVEL_W-1:0];
        REG_ATTACK: cfg_nxt.attack = cfg_data[RATE_W-1:0];
        REG_DECAY:  cfg_nxt.decay  = cfg_data[RATE_W-1:0];
        REG_THRESH: cfg_nxt.thresh = cfg_data[LEVEL_W-1:0];
        REG_SCALE:  cfg_nxt.scale  = cfg_data[RATE_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= TARGET_RST;
      cfg_r.attack <= ATTACK_RST;
      cfg_r.decay  <= DECAY_RST;
      cfg_r.thresh <= THRESH_RST;
      cfg_r.scale  <= SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/agc_ctrl.sv =====
// ----------------------------------------------------------------------------
// agc_ctrl
// Sequencer: divide steps, shared multiplier passes, output handoff.
// ----------------------------------------------------------------------------
module agc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output agc_pkg::cmd_t cmd
);
  import agc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MULG, S_MULD, S_UPD, S_MULY, S_SAT, S_MULS, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovld_r, ovld_nxt;
  logic             slot_free;

  assign slot_free = !ovld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_MULG;
        end
      end
      S_MULG: begin
        cmd.mul_g = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_MULS;
      end
      S_MULS: begin
        cmd.mul_s = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the finished result until the output register frees up
        if (slot_free) begin
          cmd.fin   = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;

endmodule

// ===== hdl/agc_dp.sv =====
// ----------------------------------------------------------------------------
// agc_dp
// Datapath: restoring divider, shared 32x17 multiplier, gain state, output.
// ----------------------------------------------------------------------------
module agc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  agc_pkg::cmd_t                  cmd,
  input  agc_pkg::cfg_t                  cfg,
  input  logic [agc_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                           in_block_start,
  output logic [agc_pkg::SAMPLE_W-1:0]   out_sample,
  output logic [agc_pkg::GAIN_W-1:0]     out_gain,
  output logic [agc_pkg::GAIN_W-1:0]     cur_gain
);
  import agc_pkg::*;

  logic                neg_r;
  logic [SAMPLE_W-1:0] xmag_r;
  logic [REM_W-1:0]    dsor_r;
  logic [REM_W-1:0]    rem_r;
  logic [Q_W-1:0]      dvd_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                lower_r;
  logic [P_W-1:0]      p_r;
  logic [P_W-1:0]      acc_r;
  logic [SAMPLE_W-1:0] y_r;
  logic                sil_r;
  logic [SAMPLE_W-1:0] osamp_r;
  logic [GAIN_W-1:0]   ogain_r;

  logic [SAMPLE_W-1:0] in_mag;
  logic [REM_W-1:0]    trial;
  logic                ge;
  logic                lower;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [SUM_W-1:0]    upd_sum;
  logic [SUM_W-1:0]    rnd_p;
  logic [SUM_W-17:0]   ymag;
  logic [SUM_W-17:0]   ylim;
  logic [SAMPLE_W-1:0] yfin;

  assign in_mag = in_sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - in_sample) : in_sample;

  // restoring divide, one quotient bit shifted into the dividend per step
  assign trial = {rem_r[REM_W-2:0], dvd_r[Q_W-1]};
  assign ge    = (trial >= dsor_r);

  assign lower = ({{(GAIN_W-Q_W){1'b0}}, dvd_r} < gain_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_g) begin
      mul_a = gain_r;
      mul_b = lower ? (W_ONE - {1'b0, cfg.attack}) : {1'b0, cfg.decay};
    end else if (cmd.mul_d) begin
      mul_a = {{(MUL_A_W-Q_W){1'b0}}, dvd_r};
      mul_b = lower_r ? {1'b0, cfg.attack} : (W_ONE - {1'b0, cfg.decay});
    end else if (cmd.mul_y) begin
      mul_a = gain_r;
      mul_b = {1'b0, xmag_r};
    end else if (cmd.mul_s) begin
      mul_a = {{(MUL_A_W-SAMPLE_W){1'b0}}, y_r};
      mul_b = {1'b0, cfg.scale};
    end
  end

  assign upd_sum = {1'b0, acc_r} + {1'b0, p_r} + ROUND;
  assign rnd_p   = {1'b0, p_r} + ROUND;
  assign ymag    = rnd_p[SUM_W-1:16];
  assign ylim    = neg_r ? (SUM_W-16)'(32768) : (SUM_W-16)'(32767);
  assign yfin    = sil_r ? rnd_p[31:16] : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_ONE;
    end else if (cmd.load && in_block_start) begin
      gain_r <= GAIN_ONE;
    end else if (cmd.upd) begin
      gain_r <= upd_sum[GAIN_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= in_sample[SAMPLE_W-1];
      xmag_r <= in_mag;
      dsor_r <= {1'b0, in_mag} + REM_W'(1);
      rem_r  <= '0;
      dvd_r  <= {cfg.target, 16'd0};
    end
    if (cmd.div_step) begin
      rem_r <= ge ? (trial - dsor_r) : trial;
      dvd_r <= {dvd_r[Q_W-2:0], ge};
    end
    if (cmd.mul_g) begin
      lower_r <= lower;
    end
    if (cmd.mul_g || cmd.mul_d || cmd.mul_y || cmd.mul_s) begin
      p_r <= P_W'(mul_a) * P_W'(mul_b);
    end
    if (cmd.mul_d) begin
      acc_r <= p_r;
    end
    if (cmd.sat) begin
      y_r <= (ymag > ylim) ? ylim[SAMPLE_W-1:0] : ymag[SAMPLE_W-1:0];
    end
    if (cmd.mul_s) begin
      sil_r <= (y_r < {1'b0, cfg.thresh});
    end
    if (cmd.fin) begin
      osamp_r <= neg_r ? (SAMPLE_W'(0) - yfin) : yfin;
      ogain_r <= gain_r;
    end
  end

  assign out_sample = osamp_r;
  assign out_gain   = ogain_r;
  assign cur_gain   = gain_r;

endmodule

// ===== hdl/automatic_gain_control.sv =====
// ----------------------------------------------------------------------------
// automatic_gain_control
// Attack/decay audio gain control with a silence clamp.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries one signed Q1.15 sample; in_tuser[0] marks the start of
//   a block and resets the kept gain to 1.0 before that sample is used.
//   out_tdata returns the gain-applied sample and the Q16.16 gain it used.
//   cfg_* writes the five setup registers by index; write only when idle.
// Processing:
//   an accepted item passes through the bit-serial divider that forms the
//   desired gain, then 7 steps of multiplier passes, gain update,
//   saturation and handoff.
//   one item is worked on at a time; the next word is taken only in the
//   idle state, after the previous item has been handed off.
// Reset:
//   rst_n low restores the setup registers to their defaults, the gain to 1.0
//   and empties the output register.
// Stall:
//   a finished result sits in the output register; the next sample is taken
//   and processed meanwhile, and waits in its last step if the slot is full.
// ----------------------------------------------------------------------------
module automatic_gain_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic [0:0]  in_tuser,   // [0] block_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] sample_out, [47:16] gain_used
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import agc_pkg::*;

  cfg_t                cfg;
  cmd_t                cmd;
  logic [SAMPLE_W-1:0] out_sample;
  logic [GAIN_W-1:0]   out_gain;
  logic [GAIN_W-1:0]   cur_gain;

  assign cfg_ready = 1'b1;

  agc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  agc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  agc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .in_sample      (in_tdata),
    .in_block_start (in_tuser[0]),
    .out_sample     (out_sample),
    .out_gain       (out_gain),
    .cur_gain       (cur_gain)
  );

  assign out_tdata = {out_gain, out_sample};

  // a word is taken only at load, so ready drops right after
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_block_start_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> (cur_gain == GAIN_ONE))
    else $error("block start did not reset gain");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.fin))
    else $error("result appeared without a finish step");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule
